>>> rtl/integer_pixel_upscaler_top_defines.svh
// ----------------------------------------------------------------------------
// Integer pixel upscaler assertion macros
// Clocked assertion helpers for the upscaler; ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PIXEL_UPSCALER_TOP_DEFINES_SVH
`define INTEGER_PIXEL_UPSCALER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define IPU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset
`define IPU_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define IPU_ASSERT(lbl, clk, rst, prop, msg)
`define IPU_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> rtl/ipu_pkg.sv
// ----------------------------------------------------------------------------
// Integer pixel upscaler package
// Shared sizes, status codes, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package ipu_pkg;

   // Line store and scale limits
   localparam int MAX_WIDTH = 2048;
   localparam int MAX_SCALE = 100;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
   localparam int SCL_W     = $clog2(MAX_SCALE + 1);
   localparam int HGT_W     = 16;
   localparam int PIX_W     = 24;

   // Register field widths
   localparam int SCALE_FW  = 7;
   localparam int WIDTH_FW  = 12;
   localparam int HEIGHT_FW = 16;

   // Configuration port
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   // Register indexes
   typedef enum logic [1:0] {
      REG_SCALE  = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2,
      REG_NONE   = 2'd3
   } reg_idx_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_ACCEPT = 3'd0,
      ST_BUSY   = 3'd1,
      ST_PIXEL  = 3'd2,
      ST_PAD    = 3'd3,
      ST_IDLE   = 3'd4
   } status_type;

   // One result item
   typedef struct packed {
      status_type status;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       row_end;
      logic       image_end;
   } result_type;

   // Effective configuration seen by the front part
   typedef struct packed {
      logic [SCL_W-1:0] scale;
      logic [CNT_W-1:0] width;
      logic [HGT_W-1:0] height;
      logic [1:0]       pad;
      logic             abort;
   } cfg_type;

endpackage

>>> rtl/ipu_req_if.sv
// ----------------------------------------------------------------------------
// Upscaler request channel
// Valid/ready channel carrying one push or pull request.
// ----------------------------------------------------------------------------
interface ipu_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] blue_in;
   logic [7:0] green_in;
   logic [7:0] red_in;

   modport source (output valid, output req_type, output blue_in, output green_in,
                   output red_in, input ready);
   modport sink   (input valid, input req_type, input blue_in, input green_in,
                   input red_in, output ready);
endinterface

>>> rtl/ipu_rsp_if.sv
// ----------------------------------------------------------------------------
// Upscaler response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ipu_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] blue_out;
   logic [7:0] green_out;
   logic [7:0] red_out;
   logic       row_end;
   logic       image_end;

   modport source (output valid, output status, output blue_out, output green_out,
                   output red_out, output row_end, output image_end, input ready);
   modport sink   (input valid, input status, input blue_out, input green_out,
                   input red_out, input row_end, input image_end, output ready);
endinterface

>>> rtl/ipu_csr.sv
// ----------------------------------------------------------------------------
// Upscaler configuration registers
// APB-style register file; keeps raw values for readback and clamped
// effective values plus the row pad length for the datapath.
// ----------------------------------------------------------------------------
module ipu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ipu_pkg::PADDR_W-1:0] paddr,
   input  logic [ipu_pkg::PDATA_W-1:0] pwdata,
   output logic [ipu_pkg::PDATA_W-1:0] prdata,
   output logic                        pready,
   output ipu_pkg::cfg_type            cfg
);

   logic [ipu_pkg::SCALE_FW-1:0]  scale_ff,  scale_in;
   logic [ipu_pkg::WIDTH_FW-1:0]  width_ff,  width_in;
   logic [ipu_pkg::HEIGHT_FW-1:0] height_ff, height_in;
   logic [ipu_pkg::SCL_W-1:0]     s_eff_ff,  s_eff_in;
   logic [ipu_pkg::CNT_W-1:0]     w_eff_ff,  w_eff_in;
   logic [ipu_pkg::HGT_W-1:0]     h_eff_ff,  h_eff_in;
   logic [1:0]                    pad_ff,    pad_in;
   logic [3:0]                    pad_prod;
   ipu_pkg::reg_idx_type          idx;
   logic                          wr;
   logic                          abort;

   assign pready = 1'b1;
   assign idx    = ipu_pkg::reg_idx_type'(paddr[3:2]);
   assign wr     = psel && penable && pwrite;

   // Decode writes; any write to a real register aborts the image
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      abort     = 1'b0;
      if (wr) begin
         unique case (idx)
            ipu_pkg::REG_SCALE: begin
               scale_in = pwdata[ipu_pkg::SCALE_FW-1:0];
               abort    = 1'b1;
            end
            ipu_pkg::REG_WIDTH: begin
               width_in = pwdata[ipu_pkg::WIDTH_FW-1:0];
               abort    = 1'b1;
            end
            ipu_pkg::REG_HEIGHT: begin
               height_in = pwdata[ipu_pkg::HEIGHT_FW-1:0];
               abort     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp to the supported ranges; pad bytes equal (width * scale) mod 4
   always_comb begin
      if (scale_in == '0) begin
         s_eff_in = ipu_pkg::SCL_W'(1);
      end else if (32'(scale_in) > ipu_pkg::MAX_SCALE) begin
         s_eff_in = ipu_pkg::SCL_W'(ipu_pkg::MAX_SCALE);
      end else begin
         s_eff_in = ipu_pkg::SCL_W'(scale_in);
      end
      if (width_in == '0) begin
         w_eff_in = ipu_pkg::CNT_W'(1);
      end else if (32'(width_in) > ipu_pkg::MAX_WIDTH) begin
         w_eff_in = ipu_pkg::CNT_W'(ipu_pkg::MAX_WIDTH);
      end else begin
         w_eff_in = ipu_pkg::CNT_W'(width_in);
      end
      h_eff_in = (height_in == '0) ? ipu_pkg::HGT_W'(1) : ipu_pkg::HGT_W'(height_in);
      pad_prod = w_eff_in[1:0] * s_eff_in[1:0];
      pad_in   = pad_prod[1:0];
   end

   // Hold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= ipu_pkg::SCALE_FW'(1);
         width_ff  <= ipu_pkg::WIDTH_FW'(1);
         height_ff <= ipu_pkg::HEIGHT_FW'(1);
         s_eff_ff  <= ipu_pkg::SCL_W'(1);
         w_eff_ff  <= ipu_pkg::CNT_W'(1);
         h_eff_ff  <= ipu_pkg::HGT_W'(1);
         pad_ff    <= 2'd1;
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         s_eff_ff  <= s_eff_in;
         w_eff_ff  <= w_eff_in;
         h_eff_ff  <= h_eff_in;
         pad_ff    <= pad_in;
      end
   end

   // Readback
   always_comb begin
      unique case (idx)
         ipu_pkg::REG_SCALE:  prdata = ipu_pkg::PDATA_W'(scale_ff);
         ipu_pkg::REG_WIDTH:  prdata = ipu_pkg::PDATA_W'(width_ff);
         ipu_pkg::REG_HEIGHT: prdata = ipu_pkg::PDATA_W'(height_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg.scale  = s_eff_ff;
   assign cfg.width  = w_eff_ff;
   assign cfg.height = h_eff_ff;
   assign cfg.pad    = pad_ff;
   assign cfg.abort  = abort;

endmodule

>>> rtl/ipu_front.sv
// ----------------------------------------------------------------------------
// Upscaler front part
// Accepts requests, keeps the row/column/repeat counters, owns the line
// store and hands one classified result per request to the queue.
// ----------------------------------------------------------------------------
module ipu_front (
   input  logic                 clock,
   input  logic                 reset,
   ipu_req_if.sink              req,
   input  ipu_pkg::cfg_type     cfg,
   output logic                 fr_valid,
   output ipu_pkg::result_type  fr_data,
   input  logic                 fr_ready
);

   logic [ipu_pkg::PIX_W-1:0] line_mem [ipu_pkg::MAX_WIDTH];
   logic [ipu_pkg::PIX_W-1:0] rd_ff;

   logic [ipu_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic                      emit_ff, emit_in;
   logic [ipu_pkg::SCL_W-1:0] rrep_ff, rrep_in;
   logic [ipu_pkg::CNT_W-1:0] col_ff,  col_in;
   logic [ipu_pkg::SCL_W-1:0] prep_ff, prep_in;
   logic [1:0]                padc_ff, padc_in;
   logic [ipu_pkg::HGT_W-1:0] rows_ff, rows_in;

   logic                      s1_valid_ff, s1_valid_in;
   ipu_pkg::status_type       s1_status_ff, res_status;
   logic                      s1_row_end_ff, res_row_end;
   logic                      s1_image_end_ff, res_image_end;

   logic                      accept;
   logic                      wr_en;
   logic                      rd_en;
   logic [ipu_pkg::CNT_W-1:0] fill_next;
   logic [ipu_pkg::CNT_W-1:0] col_next;
   logic [ipu_pkg::SCL_W-1:0] prep_next;
   logic [ipu_pkg::SCL_W-1:0] rrep_next;
   logic [2:0]                padc_next;
   logic [ipu_pkg::HGT_W-1:0] rows_next;

   // Take a new request whenever the result stage is free or moving on
   assign req.ready = !s1_valid_ff || fr_ready;
   assign accept    = req.valid && req.ready;

   assign fill_next = fill_ff + 1'b1;
   assign prep_next = prep_ff + 1'b1;
   assign rrep_next = rrep_ff + 1'b1;
   assign padc_next = {1'b0, padc_ff} + 3'd1;
   assign rows_next = rows_ff + 1'b1;

   // Classify the request and advance the counters
   always_comb begin
      fill_in       = fill_ff;
      emit_in       = emit_ff;
      rrep_in       = rrep_ff;
      col_in        = col_ff;
      prep_in       = prep_ff;
      padc_in       = padc_ff;
      rows_in       = rows_ff;
      col_next      = col_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      res_status    = ipu_pkg::ST_IDLE;
      res_row_end   = 1'b0;
      res_image_end = 1'b0;
      priority if (cfg.abort) begin
         fill_in = '0;
         emit_in = 1'b0;
         rrep_in = '0;
         col_in  = '0;
         prep_in = '0;
         padc_in = '0;
         rows_in = '0;
      end else if (accept && req.req_type == ipu_pkg::REQ_PUSH) begin
         if (emit_ff) begin
            res_status = ipu_pkg::ST_BUSY;
         end else begin
            res_status = ipu_pkg::ST_ACCEPT;
            wr_en      = 1'b1;
            fill_in    = fill_next;
            // Row complete: start emitting from the top
            if (fill_next >= cfg.width) begin
               fill_in = '0;
               emit_in = 1'b1;
               rrep_in = '0;
               col_in  = '0;
               prep_in = '0;
               padc_in = '0;
            end
         end
      end else if (accept && emit_ff) begin
         if (col_ff < cfg.width) begin
            res_status = ipu_pkg::ST_PIXEL;
            rd_en      = 1'b1;
            prep_in    = prep_next;
            if (prep_next >= cfg.scale) begin
               prep_in  = '0;
               col_next = col_ff + 1'b1;
            end
            col_in      = col_next;
            res_row_end = (col_next >= cfg.width) && (cfg.pad == 2'd0);
         end else begin
            res_status  = ipu_pkg::ST_PAD;
            padc_in     = padc_next[1:0];
            res_row_end = padc_next >= {1'b0, cfg.pad};
         end
         // Row finished: repeat it or close it
         if (res_row_end) begin
            col_in  = '0;
            prep_in = '0;
            padc_in = '0;
            rrep_in = rrep_next;
            if (rrep_next >= cfg.scale) begin
               rrep_in = '0;
               emit_in = 1'b0;
               rows_in = rows_next;
               if (rows_next >= cfg.height) begin
                  rows_in       = '0;
                  res_image_end = 1'b1;
               end
            end
         end
      end else begin
         res_status = ipu_pkg::ST_IDLE;
      end
   end

   // Hold the result stage until the queue takes it
   always_comb begin
      s1_valid_in = s1_valid_ff && !fr_ready;
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         emit_ff     <= 1'b0;
         rrep_ff     <= '0;
         col_ff      <= '0;
         prep_ff     <= '0;
         padc_ff     <= '0;
         rows_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         emit_ff     <= emit_in;
         rrep_ff     <= rrep_in;
         col_ff      <= col_in;
         prep_ff     <= prep_in;
         padc_ff     <= padc_in;
         rows_ff     <= rows_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Load result payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff    <= res_status;
         s1_row_end_ff   <= res_row_end;
         s1_image_end_ff <= res_image_end;
      end
   end

   // Line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff[ipu_pkg::ADDR_W-1:0]] <= {req.red_in, req.green_in, req.blue_in};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= line_mem[col_ff[ipu_pkg::ADDR_W-1:0]];
      end
   end

   // Drive the result; pixel bytes only for output pixels
   always_comb begin
      fr_valid          = s1_valid_ff;
      fr_data.status    = s1_status_ff;
      fr_data.row_end   = s1_row_end_ff;
      fr_data.image_end = s1_image_end_ff;
      if (s1_status_ff == ipu_pkg::ST_PIXEL) begin
         fr_data.blue  = rd_ff[7:0];
         fr_data.green = rd_ff[15:8];
         fr_data.red   = rd_ff[23:16];
      end else begin
         fr_data.blue  = '0;
         fr_data.green = '0;
         fr_data.red   = '0;
      end
   end

endmodule

>>> rtl/ipu_queue.sv
// ----------------------------------------------------------------------------
// Upscaler result queue
// Short register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module ipu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ipu_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ipu_pkg::result_type out_data
);

   ipu_pkg::result_type        slot_ff [ipu_pkg::QUEUE_DEPTH];
   logic [ipu_pkg::QPTR_W-1:0] wptr_ff, wptr_in;
   logic [ipu_pkg::QPTR_W-1:0] rptr_ff, rptr_in;
   logic [ipu_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       push;
   logic                       pop;

   assign in_ready  = count_ff != ipu_pkg::QCNT_W'(ipu_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store incoming item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/ipu_back.sv
// ----------------------------------------------------------------------------
// Upscaler back part
// Output register that presents queued results on the response channel.
// ----------------------------------------------------------------------------
module ipu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  ipu_pkg::result_type q_data,
   ipu_rsp_if.source           rsp
);

   logic                out_valid_ff, out_valid_in;
   ipu_pkg::result_type out_data_ff;

   // Refill whenever the output is empty or being taken
   assign q_ready      = !out_valid_ff || rsp.ready;
   assign out_valid_in = (q_valid && q_ready) || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) begin
         out_data_ff <= q_data;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = out_data_ff.status;
   assign rsp.blue_out  = out_data_ff.blue;
   assign rsp.green_out = out_data_ff.green;
   assign rsp.red_out   = out_data_ff.red;
   assign rsp.row_end   = out_data_ff.row_end;
   assign rsp.image_end = out_data_ff.image_end;

endmodule

>>> rtl/integer_pixel_upscaler_top.sv
// ----------------------------------------------------------------------------
// Integer pixel upscaler
// Nearest-neighbour integer upscaler for 24-bit BGR rows with row padding.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        req_type, blue_in, green_in, red_in
//   rsp_ch   out        valid/ready        status, bgr bytes, row_end, image_end
//   csr      in         APB-style, 4-bit   scale_factor, input_width, input_height
//
// One request per clock while the queue has room; each gives one result, passed
// through the result stage, a queue slot and the output register. The counters
// update once per request; the line store takes one write or one registered read per cycle.
// Synchronous reset clears all control state; no clearing pass is needed.
// A four-entry queue and an output register let the response side stall
// without stopping requests until the queue fills.
// ----------------------------------------------------------------------------
`include "integer_pixel_upscaler_top_defines.svh"

module integer_pixel_upscaler_top (
   input  logic                        clock,
   input  logic                        reset,
   ipu_req_if.sink                     req_ch,
   ipu_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ipu_pkg::PADDR_W-1:0] paddr,
   input  logic [ipu_pkg::PDATA_W-1:0] pwdata,
   output logic [ipu_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);

   ipu_pkg::cfg_type    cfg;
   logic                fr_valid;
   logic                fr_ready;
   ipu_pkg::result_type fr_data;
   logic                q_valid;
   logic                q_ready;
   ipu_pkg::result_type q_data;

   // Configuration registers
   ipu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Accept and classify requests
   ipu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg),
      .fr_valid (fr_valid),
      .fr_data  (fr_data),
      .fr_ready (fr_ready)
   );

   // Decouple front from back
   ipu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // Present results
   ipu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_data  (q_data),
      .rsp     (rsp_ch)
   );

   `IPU_ASSERT(a_image_end_on_row_end, clock, reset, (fr_valid && fr_data.image_end) |-> fr_data.row_end, "image end without row end")
   `IPU_ASSERT_NEVER(a_bytes_only_on_pixel, clock, reset, fr_valid && (fr_data.status != ipu_pkg::ST_PIXEL) && ((fr_data.blue | fr_data.green | fr_data.red) != 8'd0), "pixel bytes on a non-pixel result")
   `IPU_ASSERT_NEVER(a_flags_only_on_output, clock, reset, fr_valid && (fr_data.status == ipu_pkg::ST_ACCEPT || fr_data.status == ipu_pkg::ST_BUSY || fr_data.status == ipu_pkg::ST_IDLE) && (fr_data.row_end || fr_data.image_end), "row flag on a push or idle result")

endmodule

>>> tb/upscale_checker.sv
// ----------------------------------------------------------------------------
// Upscaler result checker
// Watches the request, response and register ports of the upscaler, keeps
// its own copy of the line buffer and emission counters, and compares every
// accepted result item field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module upscale_checker import ipu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   ipu_req_if                 req_mon,
   ipu_rsp_if                 rsp_mon,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   input  logic               pready,
   output int                 mismatch_count,
   output int                 results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted line buffer and emission progress
   logic [PIX_W-1:0]     line_mem [MAX_WIDTH];
   logic [CNT_W-1:0]     fill_cnt;
   logic                 emitting;
   logic [SCL_W-1:0]     row_rep;
   logic [SCL_W-1:0]     pix_rep;
   logic [CNT_W-1:0]     col_idx;
   logic [1:0]           pad_cnt;
   logic [HGT_W-1:0]     rows_done;

   // Register copies
   logic [SCALE_FW-1:0]  scale_reg;
   logic [WIDTH_FW-1:0]  width_reg;
   logic [HEIGHT_FW-1:0] height_reg;

   // Results owed by the block, oldest first
   result_type expected_results [$];

   function automatic void clear_progress();
      fill_cnt  = '0;
      emitting  = 1'b0;
      row_rep   = '0;
      pix_rep   = '0;
      col_idx   = '0;
      pad_cnt   = '0;
      rows_done = '0;
   endfunction

   // Work out the result of one request and advance the predicted state
   function automatic result_type upscale_step(input logic kind,
                                               input logic [PIX_W-1:0] pixel);
      result_type res;
      int s;
      int w;
      int h;
      int pad;
      s = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg));
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      h = (height_reg == 0) ? 1 : int'(height_reg);
      res = '0;
      if (kind == REQ_PUSH) begin
         if (emitting) begin
            res.status = ST_BUSY;
         end else begin
            line_mem[fill_cnt[ADDR_W-1:0]] = pixel;
            fill_cnt++;
            // Row complete: start emitting it
            if (fill_cnt >= w) begin
               fill_cnt = '0;
               emitting = 1'b1;
               row_rep  = '0;
               col_idx  = '0;
               pix_rep  = '0;
               pad_cnt  = '0;
            end
            res.status = ST_ACCEPT;
         end
      end else if (!emitting) begin
         res.status = ST_IDLE;
      end else begin
         pad = (4 - (w * s * 3) % 4) % 4;
         if (col_idx < w) begin
            res.status = ST_PIXEL;
            {res.red, res.green, res.blue} = line_mem[col_idx[ADDR_W-1:0]];
            pix_rep++;
            if (pix_rep >= s) begin
               pix_rep = '0;
               col_idx++;
            end
            if (col_idx >= w && pad == 0) res.row_end = 1'b1;
         end else begin
            res.status = ST_PAD;
            pad_cnt++;
            if (pad_cnt >= pad) res.row_end = 1'b1;
         end
         // End of an output row: repeat the row or finish it
         if (res.row_end) begin
            col_idx = '0;
            pix_rep = '0;
            pad_cnt = '0;
            row_rep++;
            if (row_rep >= s) begin
               row_rep  = '0;
               emitting = 1'b0;
               rows_done++;
               if (rows_done >= h) begin
                  rows_done     = '0;
                  res.image_end = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : track_items
      result_type want;
      if (reset) begin
         clear_progress();
         scale_reg  = 1;
         width_reg  = 1;
         height_reg = 1;
         expected_results.delete();
      end else begin
         // Register writes; any valid index aborts the image
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[PADDR_W-1:2]))
               REG_SCALE: begin
                  scale_reg = pwdata[SCALE_FW-1:0];
                  clear_progress();
               end
               REG_WIDTH: begin
                  width_reg = pwdata[WIDTH_FW-1:0];
                  clear_progress();
               end
               REG_HEIGHT: begin
                  height_reg = pwdata[HEIGHT_FW-1:0];
                  clear_progress();
               end
               default: ;
            endcase
         end

         // Compare an accepted result with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: result item with status %0d arrived, none expected",
                        $time, rsp_mon.status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("blue_out", want.blue, rsp_mon.blue_out);
               check_field("green_out", want.green, rsp_mon.green_out);
               check_field("red_out", want.red, rsp_mon.red_out);
               check_field("row_end", want.row_end, rsp_mon.row_end);
               check_field("image_end", want.image_end, rsp_mon.image_end);
            end
         end

         // Predict the result of an accepted request
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(upscale_step(req_mon.req_type,
               {req_mon.red_in, req_mon.green_in, req_mon.blue_in}));
         end
      end
      results_owed <= expected_results.size();
   end

endmodule

>>> tb/tb_integer_pixel_upscaler_top.sv
// ----------------------------------------------------------------------------
// Integer pixel upscaler testbench
// Drives push and pull requests and register writes into the upscaler with
// random gaps on both channels, a long response hold-off that backs up the
// request side, and a series of scale, width and height settings including
// the out-of-range ones. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_integer_pixel_upscaler_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ipu_pkg::*;

   localparam int REQUEST_TOTAL = 1850;
   localparam int HOLD_CYCLES   = 80;

   logic               clock;
   logic               reset;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [PDATA_W-1:0] csr_pwdata;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;
   logic               rsp_hold;
   bit                 hold_request = 1'b0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 requests_done = 0;
   int                 mismatch_count;
   int                 results_owed;

   ipu_req_if req_ch ();
   ipu_rsp_if rsp_ch ();

   integer_pixel_upscaler_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   upscale_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .pready         (csr_pready),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Accept result items at random, or not at all during the hold-off
   always @(posedge clock) begin
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold off the response side long enough for the block to back up
   initial begin : rsp_hold_off
      rsp_hold <= 1'b0;
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic issue_request(input logic kind, input logic [PIX_W-1:0] pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      {req_ch.red_in, req_ch.green_in, req_ch.blue_in} <= pixel;
      do @(posedge clock); while (!req_ch.ready);
      requests_done++;
   endtask

   // Offer one request, now and then preceded by a stray one
   task automatic offer_with_noise(input logic kind, inout int n);
      if ($urandom_range(99) < 6) begin
         issue_request(1'($urandom_range(1)), PIX_W'($urandom()));
         n++;
      end
      issue_request(kind, PIX_W'($urandom()));
      n++;
   endtask

   // Drop valid and wait until every result item has come back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic write_register(input reg_idx_type idx, input logic [PDATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Field value with random junk above the field half of the time
   function automatic logic [PDATA_W-1:0] with_spare_bits(input int value, input int field_w);
      logic [PDATA_W-1:0] spare;
      spare = $urandom_range(1) ? ($urandom() << field_w) : '0;
      return spare | PDATA_W'(value);
   endfunction

   task automatic load_settings(input int s_val, input int w_val, input int h_val);
      wait_for_results();
      write_register(REG_SCALE, with_spare_bits(s_val, SCALE_FW));
      write_register(REG_WIDTH, with_spare_bits(w_val, WIDTH_FW));
      write_register(REG_HEIGHT, with_spare_bits(h_val, HEIGHT_FW));
   endtask

   // Rows of pushes, each followed by the pulls that empty it
   task automatic run_phase(input int s_val, input int w_val, input int h_val,
                            input int budget, input bit hold_rsp);
      int s;
      int w;
      int pad;
      int row_pulls;
      int n;
      s = (s_val == 0) ? 1 : ((s_val > MAX_SCALE) ? MAX_SCALE : s_val);
      w = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : w_val);
      pad = (4 - (w * s * 3) % 4) % 4;
      row_pulls = s * (w * s + pad);
      // Stop near the overall request total
      if (budget > REQUEST_TOTAL - requests_done) budget = REQUEST_TOTAL - requests_done;
      load_settings(s_val, w_val, h_val);
      if (hold_rsp) hold_request = 1'b1;
      n = 0;
      while (n < budget) begin
         for (int i = 0; i < w && n < budget; i++) offer_with_noise(REQ_PUSH, n);
         for (int i = 0; i < row_pulls && n < budget; i++) offer_with_noise(REQ_PULL, n);
         // Now and then poke the unused register index mid-image
         if (n < budget && $urandom_range(7) == 0) begin
            wait_for_results();
            write_register(REG_NONE, $urandom());
         end
      end
   endtask

   initial begin : stimulus
      int scale_edges [4];
      int width_edges [4];
      int pick;
      bit first_phase;

      scale_edges = '{0, 100, 101, 127};
      width_edges = '{0, 2047, 2048, 4095};
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_PUSH;
      req_ch.blue_in  <= '0;
      req_ch.green_in <= '0;
      req_ch.red_in   <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 48;

      // Reset settings: pull with nothing held, then one pixel with one pad byte
      issue_request(REQ_PULL, 24'h000000);
      issue_request(REQ_PUSH, 24'hFFFFFF);
      issue_request(REQ_PUSH, 24'h000000);
      repeat (2) issue_request(REQ_PULL, 24'hFFFFFF);

      // Doubled pixel with two pad bytes, zero height acting as one
      load_settings(2, 1, 0);
      issue_request(REQ_PUSH, 24'h00FF00);
      repeat (8) issue_request(REQ_PULL, 24'h000000);

      // Three pixels with three pad bytes, first of two rows
      load_settings(1, 3, 2);
      issue_request(REQ_PUSH, 24'hAAAAAA);
      issue_request(REQ_PUSH, 24'h555555);
      issue_request(REQ_PUSH, 24'hA5F00F);
      repeat (6) issue_request(REQ_PULL, 24'hFFFFFF);

      // Zero scale and zero width acting as one
      load_settings(0, 0, 1);
      issue_request(REQ_PUSH, 24'h5A0FF0);
      repeat (2) issue_request(REQ_PULL, 24'h000000);

      // Random phases, switching the gap pattern by thirds
      first_phase = 1'b1;
      while (requests_done < REQUEST_TOTAL) begin
         if (requests_done < REQUEST_TOTAL / 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 48;
         end else if (requests_done < 2 * REQUEST_TOTAL / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = first_phase ? 9 : $urandom_range(9);
         case (pick)
            0: begin
               run_phase(scale_edges[$urandom_range(3)], $urandom_range(1, 2),
                         $urandom_range(0, 3), $urandom_range(80, 150), 1'b0);
            end
            1: begin
               run_phase($urandom_range(1, 3), width_edges[$urandom_range(3)],
                         $urandom_range(0, 3), $urandom_range(80, 150), 1'b0);
            end
            2: begin
               run_phase($urandom_range(1, 3), $urandom_range(1, 6), 65535,
                         $urandom_range(80, 200), 1'b0);
            end
            default: begin
               run_phase($urandom_range(1, 4), $urandom_range(1, 7), $urandom_range(0, 3),
                         $urandom_range(60, 240), first_phase);
            end
         endcase
         first_phase = 1'b0;
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
